FILE: hdl/thpv_pkg.sv
// Package: shared types and constants for the TCP header parser.
package thpv_pkg;
  localparam int MaxSegBytes = 65535;
  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_MALFORMED = 2'd1;
  localparam logic [1:0] ST_CSUM_BAD  = 2'd2;
  localparam logic [15:0] PROTO_TCP   = 16'd6;

  typedef enum logic [1:0] {
    PH_KIND = 2'd0,
    PH_LEN  = 2'd1,
    PH_DATA = 2'd2,
    PH_END  = 2'd3
  } opt_phase_t;

  // one's complement add of a 16-bit word into a 16-bit sum
  function automatic logic [15:0] ones_add(input logic [15:0] a, input logic [15:0] b);
    logic [16:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[15:0] + {15'd0, s[16]};
  endfunction
endpackage

FILE: hdl/thpv_core.sv
// Per-byte parser state: checksum, header fields, option walk, result build.
module thpv_core
  import thpv_pkg::*;
#(
  parameter int MAX_SEGMENT_BYTES = MaxSegBytes
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        take,
  input  logic [7:0]  b,
  input  logic        last,
  input  logic [31:0] src,
  input  logic [31:0] dst,
  output logic [1:0]  status,
  output logic [15:0] src_port,
  output logic [15:0] dst_port,
  output logic [31:0] seq_num,
  output logic [31:0] ack_num,
  output logic [3:0]  hdr_words,
  output logic [7:0]  control_flags,
  output logic [15:0] window_size,
  output logic [15:0] urg_ptr,
  output logic        mss_present,
  output logic [15:0] mss_value,
  output logic [15:0] payload_length
);
  localparam logic [16:0] MaxB = 17'(MAX_SEGMENT_BYTES);

  logic [16:0] pos_r;
  logic [15:0] sum_r;
  logic [7:0]  hi_r;
  logic        odd_r;
  logic [15:0] sp_r, dp_r, win_r, ck_r, urg_r, mss_r;
  logic [31:0] seq_r, ack_r;
  logic [3:0]  off_r;
  logic [7:0]  flg_r, orem_r;
  opt_phase_t  ph_r;
  logic        omss_r, mssp_r, obad_r, ovf_r;

  logic [15:0] s1, s2, s3, s4, sf;
  logic [15:0] pad;
  logic [16:0] cnt;
  logic [6:0]  hb;
  logic        proc;
  logic        opt_on;
  logic [7:0]  avail;
  logic [16:0] cnt_eff;

  always_comb begin
    proc   = !ovf_r && (pos_r < MaxB);
    hb     = {1'b0, off_r, 2'b00};
    // pseudo-header addresses enter with the first byte; the sum is still zero then
    s1 = sum_r;
    if (pos_r == 17'd0) begin
      s1 = ones_add(ones_add(src[31:16], src[15:0]), ones_add(dst[31:16], dst[15:0]));
    end
    s2 = s1;
    if (odd_r && pos_r != 17'd17) s2 = ones_add(s1, {hi_r, b});
    if (!proc) s2 = sum_r;
    cnt_eff = proc ? pos_r + 17'd1 : pos_r;
    // close-out terms for the last byte, summed beside the running sum
    pad = 16'd0;
    if (proc ? !odd_r : odd_r) pad = proc ? {b, 8'd0} : {hi_r, 8'd0};
    s3 = ones_add(ones_add(PROTO_TCP, cnt_eff[15:0]), pad);
    s4 = ones_add(s2, s3);
    sf = ~s4;
    cnt = cnt_eff;
    opt_on = proc && pos_r >= 17'd20 && pos_r < {10'd0, hb} && !obad_r;
    avail  = 8'(hb) - 8'(pos_r - 17'd1);
  end

  // fields as they stand after this byte, for the result
  logic [3:0]  off_n;
  logic [15:0] ck_n, urg_n;
  opt_phase_t  ph_n;
  logic        obad_n, ovf_n;
  always_comb begin
    off_n  = (proc && pos_r == 17'd12) ? b[7:4] : off_r;
    ck_n   = (proc && (pos_r == 17'd16 || pos_r == 17'd17)) ? {ck_r[7:0], b} : ck_r;
    urg_n  = (proc && (pos_r == 17'd18 || pos_r == 17'd19)) ? {urg_r[7:0], b} : urg_r;
    ovf_n  = ovf_r || (!ovf_r && pos_r >= MaxB);
    ph_n   = ph_r;
    obad_n = obad_r;
    if (opt_on) begin
      case (ph_r)
        PH_KIND: if (b == 8'd0) ph_n = PH_END; else if (b != 8'd1) ph_n = PH_LEN;
        PH_LEN: begin
          if (b < 8'd2 || b > avail) obad_n = 1'b1;
          else ph_n = (b == 8'd2) ? PH_KIND : PH_DATA;
        end
        PH_DATA: if (orem_r == 8'd1) ph_n = PH_KIND;
        default: ;
      endcase
    end
  end

  logic [15:0] mss_n;
  logic        mssp_n;
  always_comb begin
    mss_n = mss_r; mssp_n = mssp_r;
    if (opt_on && ph_r == PH_DATA && omss_r) begin
      if (orem_r == 8'd2) mss_n = {b, mss_r[7:0]};
      else if (orem_r == 8'd1) begin mss_n = {mss_r[15:8], b}; mssp_n = 1'b1; end
    end
  end

  logic [1:0] st;
  always_comb begin
    if (cnt < 17'd20 || ovf_n) st = ST_MALFORMED;
    else if (sf != ck_n) st = ST_CSUM_BAD;
    else if (off_n < 4'd5 || cnt < {11'd0, off_n, 2'b00}) st = ST_MALFORMED;
    else if (obad_n || ph_n == PH_LEN) st = ST_MALFORMED;
    else st = ST_OK;
    status = st;
    src_port       = (st == ST_OK) ? sp_r : 16'd0;
    dst_port       = (st == ST_OK) ? dp_r : 16'd0;
    seq_num        = (st == ST_OK) ? seq_r : 32'd0;
    ack_num        = (st == ST_OK) ? ack_r : 32'd0;
    hdr_words      = (st == ST_OK) ? off_n : 4'd0;
    control_flags  = (st == ST_OK) ? flg_r : 8'd0;
    window_size    = (st == ST_OK) ? win_r : 16'd0;
    urg_ptr        = (st == ST_OK) ? urg_n : 16'd0;
    mss_present    = (st == ST_OK) ? mssp_n : 1'b0;
    mss_value      = (st == ST_OK && mssp_n) ? mss_n : 16'd0;
    payload_length = (st == ST_OK) ? 16'(cnt - {11'd0, off_n, 2'b00}) : 16'd0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n || (take && last)) begin
      pos_r <= '0; sum_r <= '0; hi_r <= '0; odd_r <= 1'b0;
      sp_r <= '0; dp_r <= '0; seq_r <= '0; ack_r <= '0; off_r <= '0; flg_r <= '0;
      win_r <= '0; ck_r <= '0; urg_r <= '0; ph_r <= PH_KIND; orem_r <= '0;
      omss_r <= 1'b0; mssp_r <= 1'b0; mss_r <= '0; obad_r <= 1'b0; ovf_r <= 1'b0;
    end else if (take) begin
      ovf_r <= ovf_n;
      if (proc) begin
        pos_r <= pos_r + 17'd1;
        sum_r <= s2;
        odd_r <= !odd_r;
        if (!odd_r) hi_r <= b;
        case (pos_r[4:0])
          5'd0, 5'd1: if (pos_r < 17'd20) sp_r <= {sp_r[7:0], b};
          5'd2, 5'd3: if (pos_r < 17'd20) dp_r <= {dp_r[7:0], b};
          5'd4, 5'd5, 5'd6, 5'd7: if (pos_r < 17'd20) seq_r <= {seq_r[23:0], b};
          5'd8, 5'd9, 5'd10, 5'd11: if (pos_r < 17'd20) ack_r <= {ack_r[23:0], b};
          5'd13: if (pos_r < 17'd20) flg_r <= b;
          5'd14, 5'd15: if (pos_r < 17'd20) win_r <= {win_r[7:0], b};
          default: ;
        endcase
        off_r <= off_n; ck_r <= ck_n; urg_r <= urg_n;
        ph_r <= ph_n; obad_r <= obad_n; mss_r <= mss_n; mssp_r <= mssp_n;
        if (opt_on) begin
          if (ph_r == PH_KIND && b != 8'd0 && b != 8'd1) omss_r <= (b == 8'd2);
          if (ph_r == PH_LEN && !(b < 8'd2 || b > avail)) begin
            omss_r <= omss_r && b == 8'd4;
            orem_r <= b - 8'd2;
          end
          if (ph_r == PH_DATA) orem_r <= orem_r - 8'd1;
        end
      end
    end
  end
endmodule

FILE: hdl/tcp_header_parse_verify.sv
// Top level: TCP header parser with checksum verification, byte stream in.
// Result word is registered and appears in the cycle after the last byte is accepted.
// Throughput: one segment byte per cycle; in_tready is low only while a
//   result waits on a stalled output and another last byte arrives.
// Reset: synchronous active-low rst_n clears parser state and output valid.
// Parser state also returns to reset after every last byte.
module tcp_header_parse_verify
  import thpv_pkg::*;
#(
  parameter int MAX_SEGMENT_BYTES = MaxSegBytes
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  // seg_byte[7:0], src_addr[39:8], dst_addr[71:40]
  input  logic [71:0]  in_tdata,
  input  logic         in_tlast,
  output logic         out_tvalid,
  input  logic         out_tready,
  // status[1:0], src_port[17:2], dst_port[33:18],
  // seq_num[65:34], ack_num[97:66], hdr_words[101:98],
  // control_flags[109:102], window_size[125:110], urg_ptr[141:126],
  // mss_present[142], mss_value[158:143], payload_length[174:159], zero pad
  output logic [175:0] out_tdata
);
  logic take;
  logic [174:0] res;

  // byte without result always accepted; last byte needs a free output slot
  assign in_tready = !out_tvalid || out_tready || !in_tlast;
  assign take = in_tvalid && in_tready;

  thpv_core #(.MAX_SEGMENT_BYTES(MAX_SEGMENT_BYTES)) u_core (
    .clk, .rst_n, .take,
    .b(in_tdata[7:0]), .last(in_tlast),
    .src(in_tdata[39:8]), .dst(in_tdata[71:40]),
    .status(res[1:0]), .src_port(res[17:2]), .dst_port(res[33:18]),
    .seq_num(res[65:34]), .ack_num(res[97:66]),
    .hdr_words(res[101:98]), .control_flags(res[109:102]),
    .window_size(res[125:110]), .urg_ptr(res[141:126]),
    .mss_present(res[142]), .mss_value(res[158:143]), .payload_length(res[174:159])
  );

  logic         ov_r;
  logic [174:0] od_r;
  always_ff @(posedge clk) begin
    if (!rst_n) ov_r <= 1'b0;
    else if (take && in_tlast) ov_r <= 1'b1;
    else if (out_tready) ov_r <= 1'b0;
    if (take && in_tlast) od_r <= res;
  end
  assign out_tvalid = ov_r;
  assign out_tdata  = {1'b0, od_r};
endmodule

FILE: hdl/thpv_checker.sv
// Port-level checker for the TCP header parser, bound to the top level.
module thpv_checker (
  input logic         clk,
  input logic         rst_n,
  input logic         in_tvalid,
  input logic         in_tready,
  input logic         in_tlast,
  input logic         out_tvalid,
  input logic         out_tready,
  input logic [175:0] out_tdata
);
  a_res_follows: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && in_tlast |=> out_tvalid) else $error("no result");
  a_no_status3: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[1:0] != 2'd3) else $error("bad status");
  a_bad_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[1:0] != 2'd0 |-> out_tdata[174:2] == '0)
    else $error("fields not cleared");
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("output dropped");
endmodule

bind tcp_header_parse_verify thpv_checker u_chk (
  .clk, .rst_n, .in_tvalid, .in_tready, .in_tlast,
  .out_tvalid, .out_tready, .out_tdata
);
